// ===== sv/assert_macros.svh =====
// Assertion macros for the rotate nearest neighbor block.
// Used by the top level; needs a clock i_clk and reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition in the same cycle as its trigger
`define RNN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a condition in the cycle after its trigger
`define RNN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rnn_pkg.sv =====
// Package for the rotate nearest neighbor block: defaults, register codes, config type.
// No dependencies.
`default_nettype none
package rnn_pkg;
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int PIXEL_BITS_DEF = 32;

    localparam int FRAC_BITS = 14;
    localparam int APB_AW    = 5;

    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_COS_Q14    = 3'd4;
    localparam logic [2:0] REG_SIN_Q14    = 3'd5;

    typedef struct packed {
        logic [9:0]         src_width;
        logic [9:0]         src_height;
        logic [9:0]         dst_width;
        logic [9:0]         dst_height;
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
    } t_cfg;
endpackage
`default_nettype wire

// ===== sv/rnn_regs.sv =====
// Configuration registers behind an APB-style port.
// Depends on rnn_pkg (register codes, t_cfg).
`default_nettype none
module rnn_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [rnn_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output rnn_pkg::t_cfg                  o_cfg
);
    rnn_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= 10'd512;
            r_cfg.src_height <= 10'd512;
            r_cfg.dst_width  <= 10'd512;
            r_cfg.dst_height <= 10'd512;
            r_cfg.cos_q14    <= 16'sd16384;
            r_cfg.sin_q14    <= 16'sd0;
        end else if (w_wr) begin
            case (w_idx)
                rnn_pkg::REG_SRC_WIDTH:  r_cfg.src_width  <= pwdata[9:0];
                rnn_pkg::REG_SRC_HEIGHT: r_cfg.src_height <= pwdata[9:0];
                rnn_pkg::REG_DST_WIDTH:  r_cfg.dst_width  <= pwdata[9:0];
                rnn_pkg::REG_DST_HEIGHT: r_cfg.dst_height <= pwdata[9:0];
                rnn_pkg::REG_COS_Q14:    r_cfg.cos_q14    <= $signed(pwdata[15:0]);
                rnn_pkg::REG_SIN_Q14:    r_cfg.sin_q14    <= $signed(pwdata[15:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            rnn_pkg::REG_SRC_WIDTH:  prdata = {22'd0, r_cfg.src_width};
            rnn_pkg::REG_SRC_HEIGHT: prdata = {22'd0, r_cfg.src_height};
            rnn_pkg::REG_DST_WIDTH:  prdata = {22'd0, r_cfg.dst_width};
            rnn_pkg::REG_DST_HEIGHT: prdata = {22'd0, r_cfg.dst_height};
            rnn_pkg::REG_COS_Q14:    prdata = {16'd0, r_cfg.cos_q14};
            rnn_pkg::REG_SIN_Q14:    prdata = {16'd0, r_cfg.sin_q14};
            default:                 prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/rnn_frame_store.sv =====
// Single-port frame store with registered read data.
// No package dependencies; widths come from parameters.
`default_nettype none
module rnn_frame_store #(
    parameter int AW = 18,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== sv/rotate_nearest_neighbor_top.sv =====
// Top level of the rotate nearest neighbor block: transform pipeline around the frame store.
// Depends on rnn_pkg, rnn_regs, rnn_frame_store and assert_macros.svh.
//
// One item is accepted every clock cycle; busy stays low. A read item (opcode 1) gives
// its result on o_pixel_out and o_inside_res, marked by o_done, once it has passed the
// pipeline steps in order: center the coordinate, the four Q1.14 multiplies, the sums,
// and the bounds test with the frame store read, whose registered data drives the outputs.
// A write item (opcode 0) lands in the store at the same pipeline point, so items take
// effect in the order they are accepted. Results cannot be held off. The store is not
// cleared after reset; read only entries that were written.
`default_nettype none
`include "assert_macros.svh"
module rotate_nearest_neighbor_top #(
    parameter int MAX_WIDTH  = rnn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rnn_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = rnn_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_opcode,
    input  wire logic [9:0]                 i_coord_x,
    input  wire logic [9:0]                 i_coord_y,
    input  wire logic [31:0]                i_pixel_in,
    output logic                            o_done,
    output logic [31:0]                     o_pixel_out,
    output logic                            o_inside_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rnn_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int PW = 27;
    localparam int SW = 28;
    localparam int FB = rnn_pkg::FRAC_BITS;
    localparam logic [31:0] WHITE = 32'({PIXEL_BITS{1'b1}});

    rnn_pkg::t_cfg w_cfg;

    rnn_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic w_accept;
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // stage 1: center on the destination
    logic                  r_s1_valid, r_s1_op;
    logic [9:0]            r_s1_x, r_s1_y;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic signed [10:0]    r_s1_tx, r_s1_ty;
    logic signed [10:0]    n_s1_tx, n_s1_ty;

    assign n_s1_tx = $signed({1'b0, i_coord_x}) - $signed({2'b00, w_cfg.dst_width[9:1]});
    assign n_s1_ty = $signed({1'b0, i_coord_y}) - $signed({2'b00, w_cfg.dst_height[9:1]});

    // stage 2: products
    logic                  r_s2_valid, r_s2_op;
    logic [9:0]            r_s2_x, r_s2_y;
    logic [PIXEL_BITS-1:0] r_s2_pix;
    logic signed [PW-1:0]  r_s2_xc, r_s2_ys, r_s2_xs, r_s2_yc;
    logic signed [PW-1:0]  w_tx, w_ty, w_c, w_s;

    assign w_tx = $signed({{(PW-11){r_s1_tx[10]}}, r_s1_tx});
    assign w_ty = $signed({{(PW-11){r_s1_ty[10]}}, r_s1_ty});
    assign w_c  = $signed({{(PW-16){w_cfg.cos_q14[15]}}, w_cfg.cos_q14});
    assign w_s  = $signed({{(PW-16){w_cfg.sin_q14[15]}}, w_cfg.sin_q14});

    // stage 3: sums with the source center
    logic                  r_s3_valid, r_s3_op;
    logic [9:0]            r_s3_x, r_s3_y;
    logic [PIXEL_BITS-1:0] r_s3_pix;
    logic signed [SW-1:0]  r_s3_nx, r_s3_ny;
    logic signed [SW-1:0]  n_s3_nx, n_s3_ny;

    assign n_s3_nx = $signed({r_s2_xc[PW-1], r_s2_xc}) + $signed({r_s2_ys[PW-1], r_s2_ys})
                   + $signed({5'd0, w_cfg.src_width[9:1], 14'd0});
    assign n_s3_ny = $signed({r_s2_yc[PW-1], r_s2_yc}) - $signed({r_s2_xs[PW-1], r_s2_xs})
                   + $signed({5'd0, w_cfg.src_height[9:1], 14'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op  <= i_opcode;
        r_s1_x   <= i_coord_x;
        r_s1_y   <= i_coord_y;
        r_s1_pix <= i_pixel_in[PIXEL_BITS-1:0];
        r_s1_tx  <= n_s1_tx;
        r_s1_ty  <= n_s1_ty;

        r_s2_op  <= r_s1_op;
        r_s2_x   <= r_s1_x;
        r_s2_y   <= r_s1_y;
        r_s2_pix <= r_s1_pix;
        r_s2_xc  <= w_tx * w_c;
        r_s2_ys  <= w_ty * w_s;
        r_s2_xs  <= w_tx * w_s;
        r_s2_yc  <= w_ty * w_c;

        r_s3_op  <= r_s2_op;
        r_s3_x   <= r_s2_x;
        r_s3_y   <= r_s2_y;
        r_s3_pix <= r_s2_pix;
        r_s3_nx  <= n_s3_nx;
        r_s3_ny  <= n_s3_ny;
    end

    // stage 4: truncate toward zero, bounds test, store access
    logic [31:0]    w_w, w_h;
    logic [SW-FB-1:0] w_sx, w_sy;
    logic           w_in_x, w_in_y, w_inside, w_wr_ok;
    logic           w_mem_en;
    logic [AW-1:0]  w_addr;
    logic [PIXEL_BITS-1:0] w_rdata;

    assign w_w = (32'(w_cfg.src_width) < 32'(MAX_WIDTH)) ? 32'(w_cfg.src_width)
                                                          : 32'(MAX_WIDTH);
    assign w_h = (32'(w_cfg.src_height) < 32'(MAX_HEIGHT)) ? 32'(w_cfg.src_height)
                                                            : 32'(MAX_HEIGHT);

    assign w_sx = r_s3_nx[SW-1] ? '0 : r_s3_nx[SW-1:FB];
    assign w_sy = r_s3_ny[SW-1] ? '0 : r_s3_ny[SW-1:FB];

    assign w_in_x = r_s3_nx[SW-1]
                  ? ((&r_s3_nx[SW-1:FB]) && (|r_s3_nx[FB-1:0]) && (w_w != 32'd0))
                  : (32'(w_sx) < w_w);
    assign w_in_y = r_s3_ny[SW-1]
                  ? ((&r_s3_ny[SW-1:FB]) && (|r_s3_ny[FB-1:0]) && (w_h != 32'd0))
                  : (32'(w_sy) < w_h);
    assign w_inside = w_in_x && w_in_y;

    assign w_wr_ok = (32'(r_s3_x) < 32'(MAX_WIDTH)) && (32'(r_s3_y) < 32'(MAX_HEIGHT));

    assign w_addr = r_s3_op ? (AW'(w_sy) * AW'(MAX_WIDTH) + AW'(w_sx))
                            : (AW'(r_s3_y) * AW'(MAX_WIDTH) + AW'(r_s3_x));
    assign w_mem_en = r_s3_valid && (r_s3_op ? w_inside : w_wr_ok);

    rnn_frame_store #(
        .AW (AW),
        .DW (PIXEL_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (w_mem_en),
        .i_we    (!r_s3_op),
        .i_addr  (w_addr),
        .i_wdata (r_s3_pix),
        .o_rdata (w_rdata)
    );

    // stage 5: result
    logic r_s5_valid, r_s5_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else begin
            r_s5_valid <= r_s3_valid && r_s3_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_inside <= w_inside;
    end

    assign o_done       = r_s5_valid;
    assign o_inside_res = r_s5_inside;
    assign o_pixel_out  = r_s5_inside ? 32'(w_rdata) : WHITE;

    `RNN_ASSERT_NOW(a_outside_white, o_done && !o_inside_res, o_pixel_out == WHITE,
        "outside result is not white")
    `RNN_ASSERT_NEXT(a_read_gives_result, r_s3_valid && r_s3_op, o_done,
        "read item lost its result")
    `RNN_ASSERT_NEXT(a_write_no_result, !(r_s3_valid && r_s3_op), !o_done,
        "result without a read item")
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for rotate_nearest_neighbor_top: random pixel writes and rotated
// reads with APB register setup, checked against a behavioral rotation predictor.
// Depends on rnn_pkg and the rotate_nearest_neighbor_top RTL.
module testbench;
    localparam int          STORE_W  = rnn_pkg::MAX_WIDTH_DEF;
    localparam int          STORE_H  = rnn_pkg::MAX_HEIGHT_DEF;
    localparam int          LATENCY  = 4;
    localparam bit          OP_WRITE = 1'b0;
    localparam bit          OP_READ  = 1'b1;
    localparam logic [31:0] WHITE    = 32'hFFFF_FFFF;
    localparam real         PI       = 3.141592653589793;

    typedef struct {
        logic [31:0] pixel;
        logic        in_src;
    } t_rotated_pixel;

    class rotated_pixel_board;
        rnn_pkg::t_cfg  cfg;
        logic [31:0]    frame_copy [int];
        t_rotated_pixel expected_pixels [$];
        int             errors;

        function new();
            cfg.src_width  = 10'd512;
            cfg.src_height = 10'd512;
            cfg.dst_width  = 10'd512;
            cfg.dst_height = 10'd512;
            cfg.cos_q14    = 16'sd16384;
            cfg.sin_q14    = 16'sd0;
            errors         = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                rnn_pkg::REG_SRC_WIDTH:  cfg.src_width  = val[9:0];
                rnn_pkg::REG_SRC_HEIGHT: cfg.src_height = val[9:0];
                rnn_pkg::REG_DST_WIDTH:  cfg.dst_width  = val[9:0];
                rnn_pkg::REG_DST_HEIGHT: cfg.dst_height = val[9:0];
                rnn_pkg::REG_COS_Q14:    cfg.cos_q14    = val[15:0];
                rnn_pkg::REG_SIN_Q14:    cfg.sin_q14    = val[15:0];
                default: ;
            endcase
        endfunction

        function void map_coord(input logic [9:0] x, input logic [9:0] y,
                                output longint sx, output longint sy, output bit in_src);
            longint tx, ty, c, s, half, nx, ny, lim_w, lim_h;
            half = cfg.dst_width >> 1;
            tx = x;
            tx = tx - half;
            half = cfg.dst_height >> 1;
            ty = y;
            ty = ty - half;
            c = $signed(cfg.cos_q14);
            s = $signed(cfg.sin_q14);
            half = cfg.src_width >> 1;
            nx = tx * c + ty * s + half * 16384;
            half = cfg.src_height >> 1;
            ny = -tx * s + ty * c + half * 16384;
            sx = nx / 16384;
            sy = ny / 16384;
            lim_w = cfg.src_width;
            lim_h = cfg.src_height;
            if (lim_w > STORE_W) lim_w = STORE_W;
            if (lim_h > STORE_H) lim_h = STORE_H;
            in_src = sx >= 0 && sx < lim_w && sy >= 0 && sy < lim_h;
        endfunction

        function bit entry_known(longint sx, longint sy);
            return frame_copy.exists(int'(sy * STORE_W + sx));
        endfunction

        function void note_item(bit op, logic [9:0] x, logic [9:0] y, logic [31:0] pix);
            longint         sx, sy;
            bit             in_src;
            t_rotated_pixel r;
            if (op == OP_WRITE) begin
                if (x < STORE_W && y < STORE_H) frame_copy[int'(y) * STORE_W + int'(x)] = pix;
                return;
            end
            map_coord(x, y, sx, sy, in_src);
            r.in_src = in_src;
            r.pixel  = WHITE;
            if (in_src && entry_known(sx, sy)) r.pixel = frame_copy[int'(sy * STORE_W + sx)];
            expected_pixels.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
        endtask

        task check_result(logic [31:0] pix, logic got_in);
            t_rotated_pixel r;
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with nothing pending", pix, 32'h0);
                return;
            end
            r = expected_pixels.pop_front();
            if (got_in !== r.in_src) report_mismatch("inside_res", 32'(got_in), 32'(r.in_src));
            if (pix !== r.pixel) report_mismatch("pixel_out", pix, r.pixel);
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_opcode;
    logic [9:0]                 i_coord_x;
    logic [9:0]                 i_coord_y;
    logic [31:0]                i_pixel_in;
    logic                       o_done;
    logic [31:0]                o_pixel_out;
    logic                       o_inside_res;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [rnn_pkg::APB_AW-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    rotated_pixel_board sb = new();

    rotate_nearest_neighbor_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_pixel_in   (i_pixel_in),
        .o_done       (o_done),
        .o_pixel_out  (o_pixel_out),
        .o_inside_res (o_inside_res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #800000;
        $display("[rotate_nearest_neighbor_top] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) sb.check_result(o_pixel_out, o_inside_res);
    end

    function automatic logic [15:0] q14(real v);
        int t;
        t = int'(v * 16384.0);
        return t[15:0];
    endfunction

    task send_item(bit op, logic [9:0] x, logic [9:0] y, logic [31:0] pix);
        start      = 1'b1;
        i_opcode   = op;
        i_coord_x  = x;
        i_coord_y  = y;
        i_pixel_in = pix;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(op, x, y, pix);
        @(negedge i_clk);
    endtask

    task pause_sender(int n);
        start      = 1'b0;
        i_opcode   = 1'($urandom);
        i_coord_x  = 10'($urandom);
        i_coord_y  = 10'($urandom);
        i_pixel_in = $urandom;
        repeat (n) @(negedge i_clk);
    endtask

    // hold off until every read has returned and trailing writes have landed
    task settle();
        start = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task apb_write(logic [2:0] idx, logic [31:0] val);
        sb.set_reg(idx, val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task set_geometry(int sw, int sh, int dw, int dh, logic [15:0] c, logic [15:0] s);
        apb_write(rnn_pkg::REG_SRC_WIDTH, sw);
        apb_write(rnn_pkg::REG_SRC_HEIGHT, sh);
        apb_write(rnn_pkg::REG_DST_WIDTH, dw);
        apb_write(rnn_pkg::REG_DST_HEIGHT, dh);
        apb_write(rnn_pkg::REG_COS_Q14, {16'h0, c});
        apb_write(rnn_pkg::REG_SIN_Q14, {16'h0, s});
    endtask

    // write the mapped source entry first when it was never written
    task read_pixel(logic [9:0] x, logic [9:0] y);
        longint sx, sy;
        bit     in_src;
        sb.map_coord(x, y, sx, sy, in_src);
        if (in_src && !sb.entry_known(sx, sy)) send_item(OP_WRITE, sx[9:0], sy[9:0], $urandom);
        send_item(OP_READ, x, y, $urandom);
    endtask

    task run_phase(int n, int idle_pct);
        int         lim_w, lim_h, lim_x, lim_y;
        bit         is_write, wild;
        logic [9:0] x, y;
        lim_w = (sb.cfg.src_width > STORE_W) ? STORE_W : sb.cfg.src_width;
        lim_h = (sb.cfg.src_height > STORE_H) ? STORE_H : sb.cfg.src_height;
        if (lim_w == 0) lim_w = 16;
        if (lim_h == 0) lim_h = 16;
        lim_x = (sb.cfg.dst_width + 2 > 1023) ? 1023 : sb.cfg.dst_width + 2;
        lim_y = (sb.cfg.dst_height + 2 > 1023) ? 1023 : sb.cfg.dst_height + 2;
        repeat (n) begin
            is_write = $urandom_range(99) < 35;
            wild     = $urandom_range(7) == 0;
            if (wild) begin
                x = 10'($urandom_range(0, 1023));
                y = 10'($urandom_range(0, 1023));
            end else if (is_write) begin
                x = 10'($urandom_range(0, lim_w - 1));
                y = 10'($urandom_range(0, lim_h - 1));
            end else begin
                x = 10'($urandom_range(0, lim_x));
                y = 10'($urandom_range(0, lim_y));
            end
            if (is_write) send_item(OP_WRITE, x, y, $urandom);
            else read_pixel(x, y);
            if (idle_pct > 0 && $urandom_range(99) < idle_pct) pause_sender($urandom_range(1, 10));
        end
    endtask

    initial begin : stimulus
        logic [15:0] c, s;
        real         deg;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_opcode   = 1'b0;
        i_coord_x  = 10'd0;
        i_coord_y  = 10'd0;
        i_pixel_in = 32'd0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = 32'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity mapping after reset: corners, store edges, ignored writes
        send_item(OP_WRITE, 10'd0, 10'd0, 32'h0000_0000);
        send_item(OP_WRITE, 10'd511, 10'd511, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 10'd511, 10'd0, 32'hA5A5_A5A5);
        send_item(OP_WRITE, 10'd0, 10'd511, 32'h5A5A_5A5A);
        send_item(OP_WRITE, 10'd512, 10'd5, 32'h1234_5678);
        send_item(OP_WRITE, 10'd1023, 10'd1023, 32'h8765_4321);
        read_pixel(10'd0, 10'd0);
        read_pixel(10'd511, 10'd511);
        read_pixel(10'd511, 10'd0);
        read_pixel(10'd0, 10'd511);
        read_pixel(10'd512, 10'd512);
        read_pixel(10'd1023, 10'd1023);
        read_pixel(10'd256, 10'd256);
        run_phase(40, 30);
        settle();
        run_phase(40, 30);

        settle();
        set_geometry(16, 16, 24, 24, q14($cos(30.0 * PI / 180.0)), q14($sin(30.0 * PI / 180.0)));
        read_pixel(10'd0, 10'd0);
        read_pixel(10'd23, 10'd23);
        read_pixel(10'd12, 10'd12);
        read_pixel(10'd1023, 10'd0);
        run_phase(100, 30);

        // one-pixel source and destination, cos at -1.0 and sin at 1.0
        settle();
        set_geometry(1, 1, 1, 1, 16'hC000, 16'h4000);
        read_pixel(10'd0, 10'd0);
        read_pixel(10'd1, 10'd1);
        run_phase(40, 20);

        // zero source width: everything reads white
        settle();
        set_geometry(0, 512, 40, 40, q14(1.0), 16'h0000);
        run_phase(30, 20);

        // oversized source saturates the bounds; trig at the ends of its range
        settle();
        set_geometry(1023, 1023, 1023, 1023, 16'h8000, 16'h7FFF);
        read_pixel(10'd0, 10'd0);
        read_pixel(10'd1023, 10'd1023);
        run_phase(80, 30);

        for (int p = 0; p < 4; p++) begin
            settle();
            if ($urandom_range(3) == 0) begin
                c = 16'($urandom);
                s = 16'($urandom);
            end else begin
                deg = $urandom_range(0, 359);
                c = q14($cos(deg * PI / 180.0));
                s = q14($sin(deg * PI / 180.0));
            end
            set_geometry($urandom_range(1, 48), $urandom_range(1, 48),
                         $urandom_range(1, 80), $urandom_range(1, 80), c, s);
            run_phase(80, 25);
        end

        // back-to-back stretch, no sender gaps
        settle();
        set_geometry(32, 20, 40, 36, q14($cos(200.0 * PI / 180.0)), q14($sin(200.0 * PI / 180.0)));
        run_phase(100, 0);

        settle();
        if (sb.errors == 0) $display("[rotate_nearest_neighbor_top] OK");
        else $display("[rotate_nearest_neighbor_top] ERROR");
        $finish;
    end
endmodule
